/* hw/rtl/wbps_pkg.sv */
// Shared constants, register indexes and types of the wildcard byte pattern scanner.
`default_nettype none
package wbps_pkg;

   localparam int MAX_PATTERN_BYTES = 16;
   localparam int OFFSET_BITS       = 32;

   localparam int REG_BYTES  = 16;
   localparam int CELLS      = (MAX_PATTERN_BYTES < REG_BYTES) ? MAX_PATTERN_BYTES : REG_BYTES;
   localparam int IDX_BITS   = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int LEN_BITS   = $clog2(CELLS + 1);
   localparam int FILL_BITS  = $clog2(CELLS + 1);

   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 64;
   localparam int RSP_BITS       = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LOW  = 8'd0,
      CSR_PATTERN_HIGH = 8'd1,
      CSR_WILDCARD     = 8'd2,
      CSR_LENGTH       = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic       shift;
      logic       care;
      logic [7:0] pattern;
   } cell_ctrl_type;

endpackage
`default_nettype wire

/* hw/rtl/wbps_if.sv */
// Valid/ready channel interfaces for input bytes, results and register writes.
`default_nettype none
interface wbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_rsp_if;
   logic        valid;
   logic        ready;
   logic        match_found;
   logic [31:0] match_offset;
   logic        end_of_scan;
   logic [31:0] total_matches;

   modport source (output valid, output match_found, output match_offset,
                   output end_of_scan, output total_matches, input ready);
   modport sink (input valid, input match_found, input match_offset,
                 input end_of_scan, input total_matches, output ready);
endinterface

interface wbps_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/wbps_cell.sv */
// One window cell: holds a byte, passes it on, and compares the incoming byte.
`default_nettype none
module wbps_cell
   import wbps_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire logic [7:0]    byte_in,
   output logic [7:0]         byte_out,
   output logic               ok
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in_next;

   always_comb begin
      byte_in_next = ctrl.shift ? byte_in : byte_ff;
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_next;
   end

   assign byte_out = byte_ff;
   assign ok       = !ctrl.care || (byte_in == ctrl.pattern);

endmodule
`default_nettype wire

/* hw/rtl/wildcard_byte_pattern_scanner_core.sv */
// Top level of the wildcard byte pattern scanner: registers, cell chain, result register.
// Each accepted word is one image byte; the block takes one byte per clock and gives a result
// word in the next cycle when the window ending at that byte matches or the byte is the last of
// its image. Every cell of the window chain compares its incoming byte with the pattern byte
// that lines up with it, and the cell results are ANDed in the same cycle. The result register
// holds one word; a new byte is taken whenever that register is empty or being drained, so
// throughput stays at one byte per clock while the result side keeps up.
`default_nettype none
module wildcard_byte_pattern_scanner_core
   import wbps_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   wbps_req_if.sink   req,
   wbps_rsp_if.source rsp,
   wbps_csr_if.sink   csr
);

   logic [63:0]            pat_low_ff;
   logic [63:0]            pat_high_ff;
   logic [15:0]            wild_ff;
   logic [4:0]             len_ff;

   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [31:0]            tally_ff, tally_in;
   logic [FILL_BITS-1:0]   fill_ff, fill_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   found_ff;
   logic [31:0]            offset_ff;
   logic                   eos_ff;
   logic [31:0]            total_ff;

   logic                   accept;
   logic [4:0]             len_sel;
   logic [LEN_BITS-1:0]    len_eff;
   logic [7:0]             pat_bytes [CELLS];
   cell_ctrl_type          ctrl [CELLS];
   logic [7:0]             chain [CELLS+1];
   logic [CELLS-1:0]       ok;
   logic                   hit;
   logic [FILL_BITS-1:0]   fill_next;
   logic [OFFSET_BITS-1:0] offset;
   logic [IDX_BITS-1:0]    idx;
   int                     rel;

   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;
   assign req.ready = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         wild_ff     <= '0;
         len_ff      <= 5'd1;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_PATTERN_LOW:  pat_low_ff  <= csr.data;
            CSR_PATTERN_HIGH: pat_high_ff <= csr.data;
            CSR_WILDCARD:     wild_ff     <= csr.data[15:0];
            CSR_LENGTH:       len_ff      <= csr.data[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      len_sel = len_ff;
      if (len_sel == 5'd0) begin
         len_sel = 5'd1;
      end
      if (len_sel > 5'(CELLS)) begin
         len_sel = 5'(CELLS);
      end
      len_eff = len_sel[LEN_BITS-1:0];
   end

   always_comb begin
      for (int j = 0; j < CELLS; j++) begin
         if (j < 8) begin
            pat_bytes[j] = pat_low_ff[8*(j & 7) +: 8];
         end else begin
            pat_bytes[j] = pat_high_ff[8*(j & 7) +: 8];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < CELLS; k++) begin
         rel            = int'(len_eff) - 1 - k;
         idx            = IDX_BITS'(rel);
         ctrl[k].shift   = accept;
         ctrl[k].care    = 1'b0;
         ctrl[k].pattern = pat_bytes[idx];
         if (k < int'(len_eff)) begin
            ctrl[k].care = !wild_ff[idx];
         end
      end
   end

   assign chain[0] = req.data_byte;

   for (genvar g = 0; g < CELLS; g++) begin : g_cell
      wbps_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl[g]),
         .byte_in  (chain[g]),
         .byte_out (chain[g+1]),
         .ok       (ok[g])
      );
   end

   always_comb begin
      fill_next = (fill_ff == FILL_BITS'(CELLS)) ? fill_ff : fill_ff + FILL_BITS'(1);
      hit       = (fill_next >= FILL_BITS'(len_eff)) && (&ok);
      offset    = hit ? (pos_ff + OFFSET_BITS'(1) - OFFSET_BITS'(len_eff)) : '0;

      pos_in   = pos_ff;
      tally_in = tally_ff;
      fill_in  = fill_ff;
      if (accept) begin
         if (req.last_byte) begin
            pos_in   = '0;
            tally_in = '0;
            fill_in  = '0;
         end else begin
            pos_in  = pos_ff + OFFSET_BITS'(1);
            fill_in = fill_next;
            if (hit && (tally_ff != '1)) begin
               tally_in = tally_ff + 32'd1;
            end
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = hit || req.last_byte;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         tally_ff     <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         tally_ff     <= tally_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         found_ff  <= hit;
         offset_ff <= RSP_BITS'(offset);
         eos_ff    <= req.last_byte;
         total_ff  <= (hit && (tally_ff != '1)) ? tally_ff + 32'd1 : tally_ff;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.match_found   = found_ff;
   assign rsp.match_offset  = offset_ff;
   assign rsp.end_of_scan   = eos_ff;
   assign rsp.total_matches = total_ff;

endmodule
`default_nettype wire
